>>> src/sha1md_pkg.sv
// sha1md_pkg: shared types, constants and rotate helpers of the sha-1 digest engine
// used by sha1md_sched, sha1md_round and sha1_message_digest_top; depends on nothing
package sha1md_pkg;

    typedef logic [31:0] t_word;
    typedef logic [4:0][31:0] t_chain;

    localparam int unsigned CHAIN_WORDS = 5;
    localparam int unsigned ROUNDS      = 80;

    // element 0 holds h0
    localparam t_chain SHA1_IV = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K_R0 = 32'h5A827999;
    localparam t_word K_R1 = 32'h6ED9EBA1;
    localparam t_word K_R2 = 32'h8F1BBCDC;
    localparam t_word K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // control from the sequencer to the window and the round unit
    typedef struct packed {
        logic       push;       // shift a message or padding word into the window
        t_word      push_data;
        logic       load;       // copy chain value into working variables
        logic       round_en;   // run one compression round
        logic       fold;       // add working variables into chain value
        logic       reinit;     // back to initial hash values
        logic [6:0] round;
    } t_ctrl;

    function automatic t_word rotl1(input t_word v);
        return {v[30:0], v[31]};
    endfunction

    function automatic t_word rotl5(input t_word v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic t_word rotl30(input t_word v);
        return {v[1:0], v[31:2]};
    endfunction

endpackage

>>> src/sha1md_sched.sv
// sha1md_sched: sixteen-word message window of the sha-1 engine as a shift line
// words enter at the top; during rounds the expanded word is shifted in; uses sha1md_pkg
module sha1md_sched (
    input  logic               i_clk,
    input  sha1md_pkg::t_ctrl  i_ctrl,
    output sha1md_pkg::t_word  o_w
);
    import sha1md_pkg::*;

    t_word r_win [16];
    t_word n_ins;

    // w[t+16] from taps t+13, t+8, t+2 and t
    always_comb begin
        if (i_ctrl.push) begin
            n_ins = i_ctrl.push_data;
        end else begin
            n_ins = rotl1(r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push || i_ctrl.round_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= n_ins;
        end
    end

    assign o_w = r_win[0];

endmodule

>>> src/sha1md_round.sv
// sha1md_round: shared sha-1 round unit with working variables and chain value
// one round per cycle, then a fold cycle into the chain; uses sha1md_pkg
module sha1md_round (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1md_pkg::t_ctrl  i_ctrl,
    input  sha1md_pkg::t_word  i_w,
    output sha1md_pkg::t_chain o_chain
);
    import sha1md_pkg::*;

    t_word  r_a, r_b, r_c, r_d, r_e;
    t_chain r_chain;
    t_word  n_f, n_k, n_t;

    always_comb begin
        if (i_ctrl.round < 7'd20) begin
            n_f = (r_b & r_c) | (~r_b & r_d);
            n_k = K_R0;
        end else if (i_ctrl.round < 7'd40) begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = K_R1;
        end else if (i_ctrl.round < 7'd60) begin
            n_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            n_k = K_R2;
        end else begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = K_R3;
        end
        n_t = rotl5(r_a) + n_f + r_e + n_k + i_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_ctrl.round_en) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= rotl30(r_b);
            r_b <= r_a;
            r_a <= n_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.reinit) begin
            r_chain <= SHA1_IV;
        end else if (i_ctrl.fold) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    assign o_chain = r_chain;

endmodule

>>> src/sha1_message_digest_top.sv
// sha1_message_digest_top: sha-1 streaming digest engine, sequencer and padding
//
// input channel i_valid/o_ready moves one 32-bit big-endian message word per
// transfer, with i_byte_count (valid leading bytes, used on the last word only,
// values above 4 count as 4) and i_msg_last marking the final word.
// output channel o_valid/i_ready moves the digest as five transfers, h0 first,
// o_digest_last high on h4.
// a word that neither closes a block nor is the last leaves o_ready high. the 16th word of a block
// starts the shared round unit, which runs the 80 rounds and then a fold into the chain.
// on the last word the sequencer pushes padding and length one word per cycle,
// pausing while a block compresses, and runs one or two more blocks; the
// digest words then follow one word per cycle while i_ready is high.
// o_ready is low while a block compresses and from the last word until the last
// digest transfer. while the receiver stalls, the current digest word is held.
// after reset, and after each digest, the chain value holds the initial hash
// values and the byte count is zero; the first word may arrive at once.
// depends on sha1md_pkg, sha1md_sched and sha1md_round
module sha1_message_digest_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_msg_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word,
    output logic        o_digest_last
);
    import sha1md_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_COMP = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        P_MARK   = 3'b001,
        P_FILL   = 3'b010,
        P_LEN_LO = 3'b100
    } t_pad;

    localparam logic [6:0] FOLD_ROUND = 7'(ROUNDS);
    localparam logic [2:0] LAST_IDX   = 3'(CHAIN_WORDS - 1);

    t_state      r_state, n_state;
    t_pad        r_pad_kind;
    logic [3:0]  r_pos;
    logic [6:0]  r_round;
    logic [60:0] r_total;
    logic        r_padding;
    logic        r_final;
    logic [2:0]  r_out_idx;
    t_word       r_mark;

    logic        in_xfer, out_xfer, wrap;
    logic [2:0]  cnt_sat;
    t_word       mark_word, pad_word, len_hi, len_lo, w_cur;
    t_chain      w_chain;
    t_ctrl       ctrl;

    assign in_xfer  = i_valid && o_ready;
    assign out_xfer = o_valid && i_ready;
    assign cnt_sat  = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
    assign len_hi   = r_total[60:29];
    assign len_lo   = {r_total[28:0], 3'b000};

    // kept bytes of the last word followed by the 0x80 marker
    always_comb begin
        case (cnt_sat)
            3'd0:    mark_word = {PAD_BYTE, 24'h0};
            3'd1:    mark_word = {i_data_word[31:24], PAD_BYTE, 16'h0};
            3'd2:    mark_word = {i_data_word[31:16], PAD_BYTE, 8'h0};
            3'd3:    mark_word = {i_data_word[31:8], PAD_BYTE};
            default: mark_word = {PAD_BYTE, 24'h0};
        endcase
    end

    always_comb begin
        case (r_pad_kind)
            P_MARK:   pad_word = r_mark;
            P_FILL:   pad_word = (r_pos == 4'd14) ? len_hi : 32'h0;
            P_LEN_LO: pad_word = len_lo;
            default:  pad_word = 32'h0;
        endcase
    end

    always_comb begin
        ctrl.push      = (in_xfer && (!i_msg_last || cnt_sat == 3'd4)) || (r_state == S_PAD);
        ctrl.push_data = (r_state == S_PAD) ? pad_word : i_data_word;
        wrap           = ctrl.push && (r_pos == 4'd15);
        ctrl.load      = wrap;
        ctrl.round_en  = (r_state == S_COMP) && (r_round < FOLD_ROUND);
        ctrl.fold      = (r_state == S_COMP) && (r_round == FOLD_ROUND);
        ctrl.reinit    = out_xfer && (r_out_idx == LAST_IDX);
        ctrl.round     = r_round;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (wrap) begin
                        n_state = S_COMP;
                    end else if (i_msg_last) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (wrap) begin
                    n_state = S_COMP;
                end
            end
            S_COMP: begin
                if (ctrl.fold) begin
                    if (r_final) begin
                        n_state = S_OUT;
                    end else if (r_padding) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (ctrl.reinit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pad_kind <= P_MARK;
            r_pos      <= 4'd0;
            r_round    <= 7'd0;
            r_total    <= 61'd0;
            r_padding  <= 1'b0;
            r_final    <= 1'b0;
            r_out_idx  <= 3'd0;
        end else begin
            r_state <= n_state;
            if (ctrl.push) begin
                r_pos <= r_pos + 4'd1;
            end
            if (in_xfer) begin
                r_total <= r_total + (i_msg_last ? {58'd0, cnt_sat} : 61'd4);
                if (i_msg_last) begin
                    r_padding  <= 1'b1;
                    r_pad_kind <= P_MARK;
                    r_mark     <= mark_word;
                end
            end
            if (r_state == S_PAD) begin
                case (r_pad_kind)
                    P_MARK:   r_pad_kind <= P_FILL;
                    P_FILL: begin
                        if (r_pos == 4'd14) begin
                            r_pad_kind <= P_LEN_LO;
                        end
                    end
                    P_LEN_LO: r_final <= 1'b1;
                    default:  r_pad_kind <= P_MARK;
                endcase
            end
            if (ctrl.round_en) begin
                r_round <= r_round + 7'd1;
            end
            if (ctrl.fold) begin
                r_round <= 7'd0;
            end
            if (out_xfer) begin
                r_out_idx <= r_out_idx + 3'd1;
            end
            if (ctrl.reinit) begin
                r_out_idx <= 3'd0;
                r_total   <= 61'd0;
                r_padding <= 1'b0;
                r_final   <= 1'b0;
            end
        end
    end

    sha1md_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .o_w    (w_cur)
    );

    sha1md_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_w     (w_cur),
        .o_chain (w_chain)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = w_chain[r_out_idx];
    assign o_digest_last = (r_out_idx == LAST_IDX);

    // digest only offered once the window is empty and the round unit is parked
    a_out_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_pos == 4'd0 && r_round == 7'd0))
        else $error("digest offered with block in progress");

    // the final block must end on the low length word
    a_final_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD && r_pad_kind == P_LEN_LO) |-> (r_pos == 4'd15))
        else $error("length word not at end of block");

    // after the fifth digest transfer the next message may start
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_digest_last) |=> (o_ready && r_total == 61'd0))
        else $error("not idle after digest");

    // round counter wraps after the fold cycle
    a_fold_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.fold |=> (r_round == 7'd0 && r_state != S_COMP))
        else $error("compression did not end after fold");

endmodule
